[hdl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared payload types, controller state codes, command/status structs,
// round constants and a rotate-right helper for the SHA-256 bit functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       write_byte;  // store the input byte at the fill pointer
    logic       write_pad;   // store a padding byte at the fill pointer
    logic       start_block; // load working vars from the hash words
    logic       round;       // run one round
    logic       fold;        // add working vars into hash words
    logic       clear;       // return to initial hash, zero length
    logic       advance_out; // step the digest word pointer
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       buffer_full; // fill pointer is at the last byte slot
    logic       len_done;    // length bytes go into the current block
    logic       rounds_done;
    logic       out_last;
  } dp_stat_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

[hdl/sha256_stream_hasher_unit.sv]
// SHA-256 stream hasher, one byte per request, one request at a time.
// Absorb: the 64th byte of a block then stalls input during compression (64 rounds, fold).
// Finish: pads one byte a cycle from the marker to the block end, then compresses each block
// (one or two blocks), then eight digest words, one per cycle when not stalled.
// Reset (rst, synchronous) loads the initial hash values and clears the length.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher top level
// Joins the controller and the datapath.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_item_t out_data
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha256_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_data.data_byte),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_data)
  );

endmodule

[hdl/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte writes, padding, block compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_command,
  output logic                   in_stall,
  input  logic                   out_stall,
  output logic                   out_valid,
  input  sha256_pkg::dp_stat_t   stat,
  output sha256_pkg::dp_cmd_t    cmd
);
  import sha256_pkg::*;

  ctrl_state_t state, state_next;
  logic        finishing, finishing_next;
  logic        accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      finishing <= 1'b0;
    end else begin
      state     <= state_next;
      finishing <= finishing_next;
    end
  end

  always_comb begin
    state_next     = state;
    finishing_next = finishing;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_FINISH) begin
            finishing_next = 1'b1;
            // marker in the last slot closes the block right away
            state_next     = stat.buffer_full ? ST_ROUNDS : ST_PAD;
          end else if (stat.buffer_full) begin
            state_next = ST_ROUNDS;
          end
        end
      end
      // fill with zeros / length until the block is full, then compress
      ST_PAD: if (stat.buffer_full) state_next = ST_ROUNDS;
      ST_ROUNDS: if (stat.rounds_done) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) state_next = ST_IDLE;
        else if (stat.len_done) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (!out_stall && stat.out_last) begin
          state_next     = ST_IDLE;
          finishing_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_stall    = (state != ST_IDLE);
    out_valid   = (state == ST_EMIT);
    case (state)
      ST_IDLE: begin
        cmd.write_byte  = accept && (in_command == CMD_ABSORB);
        cmd.write_pad   = accept && (in_command == CMD_FINISH);
        cmd.start_block = accept && stat.buffer_full;
      end
      ST_PAD: begin
        cmd.write_pad   = 1'b1;
        cmd.start_block = stat.buffer_full;
      end
      ST_ROUNDS: cmd.round = 1'b1;
      ST_FOLD:   cmd.fold  = 1'b1;
      ST_EMIT: begin
        cmd.advance_out = !out_stall;
        cmd.clear       = !out_stall && stat.out_last;
      end
      default: ;
    endcase
  end

endmodule

[hdl/sha256_dp.sv]
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte shift register that doubles as the message schedule window, length
// counter, round unit and hash words.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  sha256_pkg::dp_cmd_t  cmd,
  output sha256_pkg::dp_stat_t stat,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [31:0] hash_words [8];
  logic [31:0] work [8];
  logic [31:0] sched [16];
  logic [5:0]  round_idx;
  logic        rounds_done;
  logic [2:0]  out_idx;
  logic        marker_done;
  logic        len_ok;

  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  // padding byte: zeros, then big-endian length in the last 8 slots
  assign len_shift = message_bits << {fill[2:0], 3'b000};
  assign pad_byte  = (fill >= LEN_OFFSET && len_ok) ? len_shift[63:56] : 8'h00;

  // any pad write below offset 56 leaves room for the length in this block
  always_ff @(posedge clk) begin
    if (rst) begin
      len_ok <= 1'b0;
    end else if (cmd.clear) begin
      len_ok <= 1'b0;
    end else if (cmd.write_pad && fill < LEN_OFFSET) begin
      len_ok <= 1'b1;
    end
  end

  assign wr_byte = cmd.write_byte ? in_byte : (!marker_done ? PAD_MARK : pad_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      message_bits <= '0;
      marker_done  <= 1'b0;
    end else if (cmd.clear) begin
      fill         <= '0;
      message_bits <= '0;
      marker_done  <= 1'b0;
    end else begin
      if (cmd.write_byte || cmd.write_pad) fill <= fill + 6'd1;
      if (cmd.write_byte) message_bits <= message_bits + 64'd8;
      if (cmd.write_pad) marker_done <= 1'b1;
    end
  end

  // schedule expansion and round function
  always_comb begin
    s0    = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    s1    = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    w_new = sched[0] + s0 + sched[9] + s1;
    big1  = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch    = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1    = work[7] + big1 + ch + ROUND_K[round_idx] + sched[0];
    big0  = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2    = big0 + maj;
  end

  // shift bytes in at the bottom; after 64 writes word 0 holds bytes 0..3
  always_ff @(posedge clk) begin
    if (cmd.write_byte || cmd.write_pad) begin
      for (int i = 0; i < 15; i++) sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
      sched[15] <= {sched[15][23:0], wr_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) work[i] <= hash_words[i];
    end else if (cmd.round) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_idx   <= '0;
      rounds_done <= 1'b0;
    end else if (cmd.round) begin
      round_idx   <= round_idx + 6'd1;
      rounds_done <= (round_idx == 6'd62);
    end else begin
      round_idx   <= '0;
      rounds_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_H[i];
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + work[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) out_idx <= '0;
    else if (cmd.advance_out) out_idx <= out_idx + 3'd1;
  end

  assign stat.buffer_full = (fill == 6'd63);
  assign stat.len_done    = len_ok;
  assign stat.rounds_done = rounds_done;
  assign stat.out_last    = (out_idx == 3'd7);

  assign out_item.digest_word = hash_words[out_idx];
  assign out_item.word_index  = out_idx;
  assign out_item.last        = (out_idx == 3'd7);

endmodule
